FILE: rtl/wsfr_pkg.sv
// Shared types, codes and a decode function for the frame receiver.
package wsfr_pkg;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LENGTH = 2'd1;
  localparam logic [1:0] ST_OPCODE = 2'd2;
  localparam logic [1:0] ST_ORPHAN = 2'd3;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [2:0] MT_TEXT    = 3'd0;
  localparam logic [2:0] MT_BINARY  = 3'd1;
  localparam logic [2:0] MT_CLOSE   = 3'd2;
  localparam logic [2:0] MT_PING    = 3'd3;
  localparam logic [2:0] MT_PONG    = 3'd4;
  localparam logic [2:0] MT_UNKNOWN = 3'd7;

  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [6:0] LEN_EXT16 = 7'd126;

  localparam int LenWidth = 63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [2:0] msg_type;
    logic       frame_end;
    logic       message_end;
    logic [1:0] status;
  } result_t;

  function automatic logic [2:0] type_code(input logic [3:0] op);
    logic [2:0] t;
    unique case (op)
      OP_TEXT:   t = MT_TEXT;
      OP_BINARY: t = MT_BINARY;
      OP_CLOSE:  t = MT_CLOSE;
      OP_PING:   t = MT_PING;
      OP_PONG:   t = MT_PONG;
      default:   t = MT_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/wsfr_parser.sv
// Frame header parser, length counter and payload unmasking for one byte per cycle while accept is high.
module wsfr_parser import wsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       has_result,
  output result_t    result
);

  phase_t                phase, phase_next;
  logic                  frame_fin, frame_fin_next;
  logic [3:0]            frame_type, frame_type_next;
  logic                  frame_masked, frame_masked_next;
  logic [LenWidth-1:0]   bytes_left, bytes_left_next;
  logic [2:0]            header_count, header_count_next;
  logic [31:0]           mask_key, mask_key_next;
  logic [1:0]            mask_index, mask_index_next;
  logic [3:0]            fragment_type, fragment_type_next;
  logic                  fragment_open, fragment_open_next;
  logic                  failed, failed_next;

  logic [3:0]            op;
  logic [6:0]            short_len;
  logic [7:0]            key_byte;
  logic                  do_after;
  logic                  do_start;
  logic                  masked_v;
  logic [LenWidth-1:0]   len_v;
  logic                  last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      frame_fin     <= 1'b0;
      frame_type    <= 4'd0;
      frame_masked  <= 1'b0;
      bytes_left    <= '0;
      header_count  <= 3'd0;
      mask_key      <= 32'd0;
      mask_index    <= 2'd0;
      fragment_type <= 4'd0;
      fragment_open <= 1'b0;
      failed        <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      frame_fin     <= frame_fin_next;
      frame_type    <= frame_type_next;
      frame_masked  <= frame_masked_next;
      bytes_left    <= bytes_left_next;
      header_count  <= header_count_next;
      mask_key      <= mask_key_next;
      mask_index    <= mask_index_next;
      fragment_type <= fragment_type_next;
      fragment_open <= fragment_open_next;
      failed        <= failed_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    frame_fin_next     = frame_fin;
    frame_type_next    = frame_type;
    frame_masked_next  = frame_masked;
    bytes_left_next    = bytes_left;
    header_count_next  = header_count;
    mask_key_next      = mask_key;
    mask_index_next    = mask_index;
    fragment_type_next = fragment_type;
    fragment_open_next = fragment_open;
    failed_next        = failed;
    has_result         = 1'b0;
    result             = '0;
    op                 = rx_byte[3:0];
    short_len          = rx_byte[6:0];
    do_after           = 1'b0;
    do_start           = 1'b0;
    masked_v           = frame_masked;
    len_v              = bytes_left;
    last               = 1'b0;

    unique case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase

    if (!failed) begin
      unique case (phase)
        PH_HEAD: begin
          frame_fin_next = rx_byte[7];
          if (op == OP_CONT && !fragment_open) begin
            failed_next   = 1'b1;
            has_result    = 1'b1;
            result.status = ST_ORPHAN;
          end else if (op != OP_CONT && type_code(op) == MT_UNKNOWN) begin
            failed_next   = 1'b1;
            has_result    = 1'b1;
            result.status = ST_OPCODE;
          end else begin
            if (op == OP_CONT) begin
              frame_type_next = fragment_type;
              if (rx_byte[7]) begin
                fragment_open_next = 1'b0;
                fragment_type_next = 4'd0;
              end
            end else begin
              frame_type_next = op;
              if (!rx_byte[7]) begin
                fragment_type_next = op;
                fragment_open_next = 1'b1;
              end
            end
            mask_key_next   = 32'd0;
            mask_index_next = 2'd0;
            bytes_left_next = '0;
            phase_next      = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_masked_next = rx_byte[7];
          bytes_left_next   = '0;
          if (short_len == LEN_EXT64) begin
            header_count_next = 3'd7;
            phase_next        = PH_EXT;
          end else if (short_len == LEN_EXT16) begin
            header_count_next = 3'd1;
            phase_next        = PH_EXT;
          end else begin
            bytes_left_next = {{(LenWidth-7){1'b0}}, short_len};
            len_v           = bytes_left_next;
            masked_v        = rx_byte[7];
            do_after        = 1'b1;
          end
        end
        PH_EXT: begin
          if (header_count == 3'd7 && rx_byte[7]) begin
            failed_next   = 1'b1;
            has_result    = 1'b1;
            result.status = ST_LENGTH;
          end else begin
            bytes_left_next = {bytes_left[LenWidth-9:0], rx_byte};
            if (header_count == 3'd0) begin
              len_v    = bytes_left_next;
              do_after = 1'b1;
            end else begin
              header_count_next = header_count - 3'd1;
            end
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          if (mask_index == 2'd3) begin
            do_start = 1'b1;
          end else begin
            mask_index_next = mask_index + 2'd1;
          end
        end
        PH_DATA: begin
          mask_index_next = mask_index + 2'd1;
          bytes_left_next = bytes_left - {{(LenWidth-1){1'b0}}, 1'b1};
          last            = (bytes_left_next == '0);
          if (last) begin
            phase_next = PH_HEAD;
          end
          has_result         = 1'b1;
          result.data_byte   = rx_byte ^ key_byte;
          result.data_valid  = 1'b1;
          result.msg_type    = type_code(frame_type);
          result.frame_end   = last;
          result.message_end = last & frame_fin;
          result.status      = ST_OK;
        end
        default: begin
          phase_next = PH_HEAD;
        end
      endcase

      if (do_after) begin
        if (masked_v) begin
          phase_next      = PH_KEY;
          mask_index_next = 2'd0;
        end else begin
          do_start = 1'b1;
        end
      end

      if (do_start) begin
        mask_index_next = 2'd0;
        if (len_v == '0) begin
          phase_next         = PH_HEAD;
          has_result         = 1'b1;
          result.msg_type    = type_code(frame_type);
          result.frame_end   = 1'b1;
          result.message_end = frame_fin;
          result.status      = ST_OK;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

endmodule

FILE: rtl/wsfr_out_reg.sv
// Result register that holds one word until the downstream side takes it.
module wsfr_out_reg import wsfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  input  logic    take,
  output logic    valid,
  output result_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

FILE: rtl/websocket_frame_receiver_core.sv
// A result word is offered in the cycle after the byte that causes it is accepted.
// Throughput: one received byte per cycle while rx_ready is high; each byte is resolved
// combinationally, bounded by the 63-bit payload length decrement and zero compare.
// A byte is taken whenever the result register is empty or being emptied.
// Synchronous reset returns the parser to the header phase with no fragment open.
module websocket_frame_receiver_core import wsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] data_byte,
  output logic       data_valid,
  output logic [2:0] msg_type,
  output logic       frame_end,
  output logic       message_end,
  output logic [1:0] status
);

  logic    accept;
  logic    has_result;
  result_t result;
  result_t held;

  assign rx_ready = !res_valid || res_ready;
  assign accept   = rx_valid && rx_ready;

  wsfr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .has_result (has_result),
    .result     (result)
  );

  wsfr_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (accept && has_result),
    .din   (result),
    .take  (res_ready),
    .valid (res_valid),
    .dout  (held)
  );

  assign data_byte   = held.data_byte;
  assign data_valid  = held.data_valid;
  assign msg_type    = held.msg_type;
  assign frame_end   = held.frame_end;
  assign message_end = held.message_end;
  assign status      = held.status;

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |->
      !data_valid && !frame_end && !message_end && msg_type == MT_TEXT && data_byte == 8'd0)
    else $error("Error word carries payload fields.");

  a_msg_end_in_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && message_end |-> frame_end)
    else $error("Message end without frame end.");

  a_marker_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && !data_valid && status == ST_OK |-> frame_end && data_byte == 8'd0)
    else $error("Non-data word that is not an empty-frame marker.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready)
    else $error("Input stalled while the result register is empty.");

endmodule
